// ----- src/nrtm_pkg.sv -----
// ----------------------------------------------------------------------------
// Nested region timing monitor package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package nrtm_pkg;

    localparam int NUM_REGIONS = 16;
    localparam int MAX_NEST    = 64;
    localparam int MAX_OPEN    = 1024;

    localparam int RW  = $clog2(NUM_REGIONS);
    localparam int NW  = $clog2(MAX_NEST);
    localparam int OW  = $clog2(MAX_OPEN);
    localparam int DW  = $clog2(MAX_NEST + 1);
    localparam int SSW = RW + NW;

    localparam logic [15:0] DEPTH_SAT = 16'hFFFF;

    // event codes
    localparam logic [2:0] OP_BEGIN     = 3'd0;
    localparam logic [2:0] OP_END       = 3'd1;
    localparam logic [2:0] OP_END_INNER = 3'd2;
    localparam logic [2:0] OP_CLEAR     = 3'd3;
    localparam logic [2:0] OP_READ      = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_IGNORED   = 3'd1;
    localparam logic [2:0] ST_UNMATCHED = 3'd2;
    localparam logic [2:0] ST_OPEN      = 3'd3;
    localparam logic [2:0] ST_UNTIMED   = 3'd4;

    // config register indexes
    localparam logic CFG_ENABLE  = 1'b0;
    localparam logic CFG_REGIONS = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_LOOK,
        S_EXEC,
        S_CLEAR,
        S_OUT
    } state_t;

    // controller -> datapath commands
    typedef struct packed {
        logic capture;  // latch incoming event
        logic fetch;    // read the open-order stack
        logic look;     // read the start-time stack
        logic exec;     // perform update and build result
        logic clr_step; // check one region in the clear sweep
        logic clr_init; // start clear sweep
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic clr_done;
        logic clr_refuse;
    } stat_t;

endpackage

`default_nettype wire

// ----- src/nested_region_timing_monitor_top.sv -----
// ----------------------------------------------------------------------------
// Nested region timing monitor top level
// Stream in events, stream out one status/statistics result per event.
// ----------------------------------------------------------------------------
// Sequencing: an event transfer goes through the open-order read, start-time read
// and update before its result is valid; a clear checks one region a cycle.
// Flow: one event at a time, the next taken the cycle after the result transfer.
// Reset: asynchronous active low; statistics, depths and config return to
// defaults at once, stack memories need no clearing.
`default_nettype none

module nested_region_timing_monitor_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [4:0]   cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [71:0]  s_tdata,  // op[2:0], region[6:3], timestamp[69:7]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [399:0]      m_tdata   // status, region_out, duration, calls,
                                        // completed, total_time, min_time,
                                        // max_time, open_level
);
    import nrtm_pkg::*;

    cmd_t  cmd;
    stat_t st;
    logic  in_fire, out_fire;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    logic [2:0]  status;
    logic [3:0]  region_out;
    logic [63:0] duration, total_time, min_time, max_time;
    logic [62:0] calls, completed;
    logic [6:0]  open_level;

    nrtm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .is_clear (s_tdata[2:0] == OP_CLEAR),
        .out_fire (out_fire),
        .st       (st),
        .cmd      (cmd),
        .s_ready  (s_tready),
        .m_valid  (m_tvalid)
    );

    nrtm_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_index),
        .cfg_data   (cfg_data),
        .op         (s_tdata[2:0]),
        .region     (s_tdata[6:3]),
        .timestamp  (s_tdata[69:7]),
        .status     (status),
        .region_out (region_out),
        .duration   (duration),
        .calls      (calls),
        .completed  (completed),
        .total_time (total_time),
        .min_time   (min_time),
        .max_time   (max_time),
        .open_level (open_level)
    );

    assign m_tdata = {4'b0, open_level, max_time, min_time, total_time, completed,
                      calls, duration, region_out, status};

endmodule

`default_nettype wire

// ----- src/nrtm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Nested region timing monitor controller
// Sequences capture, memory fetch, update, clear sweep and result hold.
// ----------------------------------------------------------------------------
`default_nettype none

module nrtm_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_fire,
    input  wire logic            is_clear,
    input  wire logic            out_fire,
    input  wire nrtm_pkg::stat_t st,
    output nrtm_pkg::cmd_t       cmd,
    output logic                 s_ready,
    output logic                 m_valid
);
    import nrtm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_fire) state_next = is_clear ? S_CLEAR : S_FETCH;
            S_FETCH: state_next = S_LOOK;
            S_LOOK:  state_next = S_EXEC;
            S_EXEC:  state_next = S_OUT;
            S_CLEAR: if (st.clr_refuse || st.clr_done) state_next = S_OUT;
            S_OUT:   if (out_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        s_ready  = 1'b0;
        m_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_ready      = 1'b1;
                cmd.capture  = in_fire;
                cmd.clr_init = in_fire && is_clear;
            end
            S_FETCH: cmd.fetch = 1'b1;
            S_LOOK:  cmd.look = 1'b1;
            S_EXEC:  cmd.exec = 1'b1;
            S_CLEAR: cmd.clr_step = 1'b1;
            S_OUT:   m_valid = 1'b1;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/nrtm_dp.sv -----
// ----------------------------------------------------------------------------
// Nested region timing monitor datapath
// Per-region counters, start-time and open-order memories, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nrtm_dp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire nrtm_pkg::cmd_t cmd,
    output nrtm_pkg::stat_t     st,
    input  wire logic           cfg_we,
    input  wire logic           cfg_idx,
    input  wire logic [4:0]     cfg_data,
    input  wire logic [2:0]     op,
    input  wire logic [3:0]     region,
    input  wire logic [62:0]    timestamp,
    output logic [2:0]          status,
    output logic [3:0]          region_out,
    output logic [63:0]         duration,
    output logic [62:0]         calls,
    output logic [62:0]         completed,
    output logic [63:0]         total_time,
    output logic [63:0]         min_time,
    output logic [63:0]         max_time,
    output logic [6:0]          open_level
);
    import nrtm_pkg::*;

    // configuration
    logic       enable_reg;
    logic [4:0] regions_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b1;
            regions_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == CFG_ENABLE)
                enable_reg <= cfg_data[0];
            else
                regions_reg <= cfg_data;
        end
    end

    logic [5:0] nvalid;
    assign nvalid = (regions_reg < 5'(NUM_REGIONS)) ? {1'b0, regions_reg} : 6'(NUM_REGIONS);

    // per-region state
    logic [DW-1:0] depth_reg [NUM_REGIONS];
    logic [63:0]   call_reg  [NUM_REGIONS];
    logic [63:0]   comp_reg  [NUM_REGIONS];
    logic [63:0]   sum_reg   [NUM_REGIONS];
    logic [63:0]   least_reg [NUM_REGIONS];
    logic [63:0]   most_reg  [NUM_REGIONS];
    logic [15:0]   odepth_reg;

    // memories
    logic [63:0]   start_mem [NUM_REGIONS*MAX_NEST];
    logic [RW-1:0] order_mem [MAX_OPEN];
    logic [63:0]   start_rd_reg;
    logic [RW-1:0] order_rd_reg;

    // captured event
    logic [2:0]  op_reg;
    logic [3:0]  rg_reg;
    logic [63:0] ts_reg;
    logic        en_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= op;
            rg_reg <= region;
            ts_reg <= {1'b0, timestamp};
            en_reg <= enable_reg;
        end
    end

    // open-order top address after pop
    logic [15:0] odepth_m1;
    assign odepth_m1 = odepth_reg - 16'd1;

    // fetch: region id under the shared top
    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
            order_rd_reg <= order_mem[odepth_m1[OW-1:0]];
    end

    // target region: shared top for end innermost, else the event's region
    logic          inner;
    logic [RW-1:0] rsel;
    logic [DW-1:0] dcur;
    logic [DW-1:0] dm1;
    assign inner = (op_reg == OP_END_INNER);
    assign rsel  = inner ? order_rd_reg : rg_reg[RW-1:0];
    assign dcur  = depth_reg[rsel];
    assign dm1   = dcur - DW'(1);

    // lookup: innermost open start time of the target region
    always_ff @(posedge clk)
    begin
        if (cmd.look)
            start_rd_reg <= start_mem[{rsel, dm1[NW-1:0]}];
    end

    // ------------------------------------------------------------------
    // Exec: decide and update
    // ------------------------------------------------------------------
    logic        rg_valid;
    logic        tg_valid;
    logic [63:0] dur;
    logic        first;
    assign rg_valid = ({2'b0, rg_reg} < nvalid);
    assign tg_valid = ({2'b0, rsel} < nvalid);
    assign dur      = ts_reg - start_rd_reg;
    assign first    = (comp_reg[rsel] == 64'd0);

    logic [2:0] res_st;
    logic [3:0] res_rg;
    logic       do_begin, do_fin, do_pop;

    always_comb
    begin
        res_st   = ST_OK;
        res_rg   = rg_reg;
        do_begin = 1'b0;
        do_fin   = 1'b0;
        do_pop   = 1'b0;
        if (!en_reg || op_reg > OP_READ)
            res_st = ST_IGNORED;
        else
        begin
            case (op_reg)
                OP_BEGIN:
                begin
                    if (!rg_valid) res_st = ST_IGNORED;
                    else
                    begin
                        do_begin = 1'b1;
                        if (dcur >= DW'(MAX_NEST)) res_st = ST_UNTIMED;
                    end
                end
                OP_END:
                begin
                    if (!rg_valid) res_st = ST_IGNORED;
                    else if (dcur == '0) res_st = ST_UNMATCHED;
                    else
                    begin
                        do_fin = 1'b1;
                        do_pop = (odepth_reg != '0);
                    end
                end
                OP_END_INNER:
                begin
                    // the shared depth pops even when the end fails
                    do_pop = (odepth_reg != '0);
                    if (odepth_reg == '0 || odepth_m1 >= 16'(MAX_OPEN) ||
                        !tg_valid || dcur == '0)
                    begin
                        res_st = ST_UNMATCHED;
                        res_rg = '0;
                    end
                    else
                    begin
                        do_fin = 1'b1;
                        res_rg = 4'(rsel);
                    end
                end
                OP_READ: if (!rg_valid) res_st = ST_IGNORED;
                default: res_st = ST_IGNORED;
            endcase
        end
    end

    // clear sweep: one region checked a cycle, the live regions zeroed at the end
    logic [RW:0] clr_i_reg;
    logic        clr_past;
    logic        clr_open;
    assign clr_past = ({1'b0, clr_i_reg} >= nvalid);
    assign clr_open = !clr_past && (depth_reg[clr_i_reg[RW-1:0]] != '0);

    always_comb
    begin
        st.clr_refuse = cmd.clr_step && en_reg && clr_open;
        st.clr_done   = cmd.clr_step && (!en_reg || clr_past);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odepth_reg <= '0;
            clr_i_reg  <= '0;
            for (int i = 0; i < NUM_REGIONS; i++)
            begin
                depth_reg[i] <= '0;
                call_reg[i]  <= '0;
                comp_reg[i]  <= '0;
                sum_reg[i]   <= '0;
                least_reg[i] <= '0;
                most_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cmd.clr_init)
                clr_i_reg <= '0;
            if (cmd.exec)
            begin
                if (do_begin)
                begin
                    call_reg[rsel] <= call_reg[rsel] + 64'd1;
                    if (dcur < DW'(MAX_NEST))
                    begin
                        depth_reg[rsel] <= dcur + DW'(1);
                        if (odepth_reg != DEPTH_SAT)
                            odepth_reg <= odepth_reg + 16'd1;
                    end
                end
                if (do_pop)
                    odepth_reg <= odepth_m1;
                if (do_fin)
                begin
                    depth_reg[rsel] <= dm1;
                    comp_reg[rsel]  <= comp_reg[rsel] + 64'd1;
                    sum_reg[rsel]   <= sum_reg[rsel] + dur;
                    if (first || $signed(dur) < $signed(least_reg[rsel]))
                        least_reg[rsel] <= dur;
                    if (first || $signed(most_reg[rsel]) < $signed(dur))
                        most_reg[rsel] <= dur;
                end
            end
            if (cmd.clr_step && en_reg)
            begin
                if (clr_past)
                begin
                    for (int i = 0; i < NUM_REGIONS; i++)
                    begin
                        if (i < int'(nvalid))
                        begin
                            call_reg[i]  <= '0;
                            comp_reg[i]  <= '0;
                            sum_reg[i]   <= '0;
                            least_reg[i] <= '0;
                            most_reg[i]  <= '0;
                        end
                    end
                    odepth_reg <= '0;
                end
                else if (!clr_open)
                    clr_i_reg <= clr_i_reg + 1'b1;
            end
        end
    end

    // memory writes
    always_ff @(posedge clk)
    begin
        if (cmd.exec && do_begin && dcur < DW'(MAX_NEST))
        begin
            start_mem[{rsel, dcur[NW-1:0]}] <= ts_reg;
            if (odepth_reg < 16'(MAX_OPEN))
                order_mem[odepth_reg[OW-1:0]] <= rsel;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [2:0]  rstat_reg;
    logic [3:0]  rrg_reg;
    logic [63:0] rdur_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rstat_reg <= res_st;
            rrg_reg   <= res_rg;
            rdur_reg  <= do_fin ? dur : 64'd0;
        end
        else if (cmd.clr_init)
        begin
            rrg_reg   <= region;
            rdur_reg  <= '0;
            rstat_reg <= enable_reg ? ST_OK : ST_IGNORED;
        end
        else if (st.clr_refuse)
            rstat_reg <= ST_OPEN;
    end

    // statistics only for a valid region that was not ignored or a failed innermost end
    logic          show;
    logic [RW-1:0] ri;
    assign show = ({2'b0, rrg_reg} < nvalid) && (rstat_reg != ST_IGNORED) &&
                  !(rstat_reg == ST_UNMATCHED && op_reg == OP_END_INNER);
    assign ri   = rrg_reg[RW-1:0];

    assign status     = rstat_reg;
    assign region_out = rrg_reg;
    assign duration   = rdur_reg;
    assign calls      = show ? call_reg[ri][62:0] : '0;
    assign completed  = show ? comp_reg[ri][62:0] : '0;
    assign total_time = show ? sum_reg[ri] : '0;
    assign min_time   = show ? least_reg[ri] : '0;
    assign max_time   = show ? most_reg[ri] : '0;
    assign open_level = show ? 7'(depth_reg[ri]) : '0;

endmodule

`default_nettype wire

// ----- src/nrtm_checker.sv -----
// ----------------------------------------------------------------------------
// Nested region timing monitor port checker
// Watches handshake ordering and result field ranges at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module nrtm_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [399:0] m_tdata
);
    // a result stays until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");

    // no new event while a result is pending
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input open while result pending");

    // status is a defined code
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= 3'd4)
        else $error("bad status");

    // an accepted event produces no result in the next cycle
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !m_tvalid)
        else $error("result too early");

endmodule

bind nested_region_timing_monitor_top nrtm_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- verif/nested_region_timing_monitor_checker.sv -----
// ----------------------------------------------------------------------------
// Nested region timing monitor checker
// Watches the config port and both stream channels, predicts each result
// from its own model of the region stacks and statistics, and compares every
// result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module nested_region_timing_monitor_checker
    import nrtm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [4:0]   cfg_data,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [71:0]  s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [399:0] m_tdata,
    output int                mismatches,
    output int                outstanding,
    output int                results_seen
);

    typedef struct packed {
        logic [6:0]  open_level;
        logic [63:0] max_time;
        logic [63:0] min_time;
        logic [63:0] total_time;
        logic [62:0] completed;
        logic [62:0] calls;
        logic [63:0] duration;
        logic [3:0]  region_out;
        logic [2:0]  status;
    } stats_t;

    // predictor state
    logic        on_flag;
    logic [4:0]  regions_cfg;
    logic [6:0]  nest_level [NUM_REGIONS];
    logic [63:0] open_start [NUM_REGIONS*MAX_NEST];
    logic [63:0] n_calls    [NUM_REGIONS];
    logic [63:0] n_done     [NUM_REGIONS];
    logic [63:0] sum_t      [NUM_REGIONS];
    logic [63:0] least_t    [NUM_REGIONS];
    logic [63:0] most_t     [NUM_REGIONS];
    logic [3:0]  shared_ids [MAX_OPEN];
    logic [15:0] shared_lvl;

    stats_t expected_stats [$];

    function automatic int live_regions();
        return (regions_cfg < NUM_REGIONS) ? int'(regions_cfg) : NUM_REGIONS;
    endfunction

    function automatic stats_t region_stats(logic [2:0] st, int r, logic [63:0] dur);
        stats_t s;
        s = '0;
        s.status     = st;
        s.region_out = r[3:0];
        s.duration   = dur;
        if (r < live_regions())
        begin
            s.calls      = n_calls[r][62:0];
            s.completed  = n_done[r][62:0];
            s.total_time = sum_t[r];
            s.min_time   = least_t[r];
            s.max_time   = most_t[r];
            s.open_level = nest_level[r];
        end
        return s;
    endfunction

    // pop one call of region r and fold its duration into the statistics
    function automatic logic [63:0] close_call(int r, logic [63:0] now);
        logic [63:0] dur;
        nest_level[r] = nest_level[r] - 7'd1;
        dur = now - open_start[r*MAX_NEST + int'(nest_level[r])];
        if (n_done[r] == 0)
        begin
            least_t[r] = dur;
            most_t[r]  = dur;
        end
        else
        begin
            if ($signed(dur) < $signed(least_t[r])) least_t[r] = dur;
            if ($signed(most_t[r]) < $signed(dur))  most_t[r]  = dur;
        end
        sum_t[r]  = sum_t[r] + dur;
        n_done[r] = n_done[r] + 64'd1;
        return dur;
    endfunction

    function automatic stats_t predict_event(logic [2:0] op, int r, logic [63:0] now);
        stats_t s;
        int n;
        int top;
        bit busy;
        n = live_regions();
        if (!on_flag || op > OP_READ)
        begin
            s = '0;
            s.status = ST_IGNORED;
            s.region_out = r[3:0];
            return s;
        end
        case (op)
            OP_BEGIN:
            begin
                if (r >= n) return region_stats(ST_IGNORED, r + 16, 64'd0);
                n_calls[r] = n_calls[r] + 64'd1;
                if (nest_level[r] >= MAX_NEST) return region_stats(ST_UNTIMED, r, 64'd0);
                open_start[r*MAX_NEST + int'(nest_level[r])] = now;
                nest_level[r] = nest_level[r] + 7'd1;
                if (shared_lvl < MAX_OPEN) shared_ids[shared_lvl] = r[3:0];
                if (shared_lvl < DEPTH_SAT) shared_lvl = shared_lvl + 16'd1;
                return region_stats(ST_OK, r, 64'd0);
            end
            OP_END:
            begin
                if (r >= n) return region_stats(ST_IGNORED, r + 16, 64'd0);
                if (nest_level[r] == 0) return region_stats(ST_UNMATCHED, r, 64'd0);
                if (shared_lvl > 0) shared_lvl = shared_lvl - 16'd1;
                return region_stats(ST_OK, r, close_call(r, now));
            end
            OP_END_INNER:
            begin
                if (shared_lvl == 0) return region_stats(ST_UNMATCHED, 16, 64'd0);
                shared_lvl = shared_lvl - 16'd1;
                if (shared_lvl >= MAX_OPEN) return region_stats(ST_UNMATCHED, 16, 64'd0);
                top = int'(shared_ids[shared_lvl]);
                if (top >= n || nest_level[top] == 0)
                    return region_stats(ST_UNMATCHED, 16, 64'd0);
                return region_stats(ST_OK, top, close_call(top, now));
            end
            OP_CLEAR:
            begin
                busy = 0;
                for (int i = 0; i < n; i++)
                    if (nest_level[i] != 0) busy = 1;
                if (busy) return region_stats(ST_OPEN, r, 64'd0);
                for (int i = 0; i < n; i++)
                begin
                    n_calls[i] = 0;
                    n_done[i]  = 0;
                    sum_t[i]   = 0;
                    least_t[i] = 0;
                    most_t[i]  = 0;
                end
                shared_lvl = 0;
                return region_stats(ST_OK, r, 64'd0);
            end
            default:
            begin
                if (r >= n) return region_stats(ST_IGNORED, r + 16, 64'd0);
                return region_stats(ST_OK, r, 64'd0);
            end
        endcase
    endfunction

    assign outstanding = expected_stats.size();

    // result side first, then config, then a new event
    always @(posedge clk or negedge rst_n)
    begin
        stats_t got;
        stats_t exp_s;
        if (!rst_n)
        begin
            on_flag     = 1'b1;
            regions_cfg = '0;
            shared_lvl  = '0;
            for (int i = 0; i < NUM_REGIONS; i++)
            begin
                nest_level[i] = '0;
                n_calls[i]    = '0;
                n_done[i]     = '0;
                sum_t[i]      = '0;
                least_t[i]    = '0;
                most_t[i]     = '0;
            end
            expected_stats.delete();
            mismatches   <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                got = m_tdata[395:0];
                if (expected_stats.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("%0t: result transfer with none expected: %h", $realtime,
                                 m_tdata);
                end
                else
                begin
                    exp_s = expected_stats.pop_front();
                    if (got.status !== exp_s.status || got.region_out !== exp_s.region_out
                        || got.duration !== exp_s.duration || got.calls !== exp_s.calls
                        || got.completed !== exp_s.completed
                        || got.total_time !== exp_s.total_time
                        || got.min_time !== exp_s.min_time || got.max_time !== exp_s.max_time
                        || got.open_level !== exp_s.open_level)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                        begin
                            $display("%0t: mismatch st %0d/%0d reg %0d/%0d dur %h/%h",
                                     $realtime, exp_s.status, got.status, exp_s.region_out,
                                     got.region_out, exp_s.duration, got.duration);
                            $display("  calls %0d/%0d done %0d/%0d sum %h/%h",
                                     exp_s.calls, got.calls, exp_s.completed, got.completed,
                                     exp_s.total_time, got.total_time);
                            $display("  min %h/%h max %h/%h level %0d/%0d",
                                     exp_s.min_time, got.min_time, exp_s.max_time,
                                     got.max_time, exp_s.open_level, got.open_level);
                        end
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_ENABLE) on_flag = cfg_data[0];
                else regions_cfg = cfg_data;
            end
            if (s_tvalid && s_tready)
                expected_stats.push_back(predict_event(s_tdata[2:0], int'(s_tdata[6:3]),
                                                       {1'b0, s_tdata[69:7]}));
        end
    end

endmodule

// ----- verif/nested_region_timing_monitor_top_tb.sv -----
// ----------------------------------------------------------------------------
// Nested region timing monitor testbench
// Drives directed and random begin/end/clear/read events through several
// enable and region-count settings with random idling on both channels; the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module nested_region_timing_monitor_top_tb;
    import nrtm_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic         cfg_index;
    logic [4:0]   cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [399:0] m_tdata;
    int           mismatches;
    int           outstanding;
    int           results_seen;

    // stimulus controls
    bit           gaps_on;
    bit           long_hold;
    logic [62:0]  wall_ns;
    int           live_cnt;
    int           events_sent;

    nested_region_timing_monitor_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    nested_region_timing_monitor_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #5_000_000;
        $display("nested_region_timing_monitor_top_tb failed");
        $finish;
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                m_tready <= 1'b0;
                for (int k = 0; k < 300; k++) @(posedge clk);
                long_hold = 0;
                m_tready <= 1'b1;
            end
            else if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // one event transfer; valid stays high between back-to-back events unless a random gap is drawn
    task automatic send_event(logic [2:0] op, logic [3:0] reg_no, logic [62:0] stamp);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b0, stamp, reg_no, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        events_sent++;
    endtask

    // mostly increasing time, occasionally anything
    function automatic logic [62:0] next_stamp();
        if ($urandom_range(0, 30) == 0)
            return 63'({$urandom, $urandom});
        wall_ns = wall_ns + 63'($urandom_range(0, 2000));
        return wall_ns;
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_events(int count);
        int pick;
        logic [3:0] reg_no;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (live_cnt > 0 && $urandom_range(0, 9) != 0)
                reg_no = 4'($urandom_range(0, live_cnt - 1));
            else
                reg_no = 4'($urandom);
            if (pick < 38)      send_event(OP_BEGIN, reg_no, next_stamp());
            else if (pick < 63) send_event(OP_END, reg_no, next_stamp());
            else if (pick < 80) send_event(OP_END_INNER, reg_no, next_stamp());
            else if (pick < 90) send_event(OP_READ, reg_no, next_stamp());
            else if (pick < 96) send_event(OP_CLEAR, reg_no, next_stamp());
            else                send_event(3'($urandom_range(5, 7)), reg_no, next_stamp());
        end
    endtask

    task automatic close_all();
        for (int k = 0; k < 40; k++) send_event(OP_END_INNER, 4'd0, next_stamp());
        for (int r = 0; r < NUM_REGIONS; r++)
            for (int k = 0; k < 2; k++) send_event(OP_END, 4'(r), next_stamp());
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_ENABLE;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        gaps_on   = 1;
        long_hold = 0;
        wall_ns   = '0;
        live_cnt  = 0;
        events_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset config first, then all regions live
        send_event(OP_BEGIN, 4'd0, 63'd0);
        drain();
        write_reg(CFG_REGIONS, 5'd16);
        live_cnt = 16;
        send_event(OP_BEGIN, 4'd0, 63'd0);
        send_event(OP_READ, 4'd0, 63'd5);
        send_event(OP_END, 4'd0, {63{1'b1}});
        send_event(OP_END, 4'd0, {63{1'b1}});
        send_event(OP_END_INNER, 4'd0, 63'd10);
        send_event(OP_BEGIN, 4'd15, {63{1'b1}});
        send_event(OP_BEGIN, 4'd15, 63'd100);
        send_event(OP_END_INNER, 4'd9, 63'd50);
        send_event(OP_END_INNER, 4'd9, 63'd200);
        send_event(OP_BEGIN, 4'd3, 63'd300);
        send_event(OP_CLEAR, 4'd7, 63'd310);
        send_event(OP_END, 4'd3, 63'd400);
        send_event(OP_CLEAR, 4'd7, 63'd410);
        send_event(3'd5, 4'd1, 63'd0);
        send_event(3'd6, 4'd2, 63'd0);
        send_event(3'd7, 4'd15, {63{1'b1}});
        send_event(OP_READ, 4'd15, 63'd500);
        // nest one region past its limit, then unwind
        for (int k = 0; k < MAX_NEST + 2; k++) send_event(OP_BEGIN, 4'd1, 63'd1000 + k);
        for (int k = 0; k < MAX_NEST + 1; k++) send_event(OP_END, 4'd1, 63'd5000 + k);
        drain();

        // random phases through region-count and enable settings
        wall_ns = 63'd10000;
        write_reg(CFG_REGIONS, 5'd5);
        live_cnt = 5;
        random_events(40);
        drain();
        write_reg(CFG_REGIONS, 5'd31);
        live_cnt = 16;
        long_hold = 1;
        random_events(60);
        drain();
        write_reg(CFG_ENABLE, 5'd0);
        random_events(20);
        drain();
        write_reg(CFG_ENABLE, 5'd1);
        write_reg(CFG_REGIONS, 5'd0);
        live_cnt = 0;
        random_events(20);
        drain();
        write_reg(CFG_REGIONS, 5'd1);
        live_cnt = 1;
        random_events(30);
        drain();
        write_reg(CFG_REGIONS, 5'd16);
        live_cnt = 16;
        random_events(60);
        close_all();
        send_event(OP_CLEAR, 4'd2, next_stamp());
        drain();
        write_reg(CFG_REGIONS, 5'd8);
        live_cnt = 8;
        gaps_on = 0;
        random_events(50);
        drain();

        repeat (NUM_REGIONS + 10) @(posedge clk);
        $display("Covered %0d events, %0d results, over enable off/on and 0..31 regions,",
                 events_sent, results_seen);
        $display("with nesting overflow, unmatched ends, refused clears and long stalls.");
        if (mismatches == 0 && outstanding == 0)
            $display("nested_region_timing_monitor_top_tb passed");
        else
            $display("nested_region_timing_monitor_top_tb failed");
        $finish;
    end

endmodule

// ----- sim.f -----
src/nrtm_pkg.sv
src/nrtm_ctrl.sv
src/nrtm_dp.sv
src/nested_region_timing_monitor_top.sv
src/nrtm_checker.sv
verif/nested_region_timing_monitor_checker.sv
verif/nested_region_timing_monitor_top_tb.sv
